// File: src/tsa_pkg.sv
// Shared types and constants for the tangent space accumulator.
// Holds the command codes, state encodings and the controller to datapath
// command and status structs. No dependencies.
package tsa_pkg;

    localparam int IDX_W     = 10;
    localparam int S_TDATA_W = 288;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 208;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_code_t;

    typedef enum logic [5:0] {
        S_IDLE, S_DECODE, S_LOAD,
        S_TRI_RD_A, S_TRI_RD_B, S_TRI_RD_C, S_TRI_DIFF,
        S_MUL_0, S_MUL_1, S_MUL_2, S_MUL_3, S_MUL_4,
        S_MUL_5, S_MUL_6, S_MUL_7, S_MUL_8, S_MUL_9,
        S_TN_GO, S_TN_WAIT, S_NN_GO, S_NN_WAIT,
        S_BT_0, S_BT_1, S_BT_2, S_BT_3, S_BT_4, S_BT_5, S_BT_6, S_BT_7,
        S_AC_RD_A, S_AC_WR_A, S_AC_RD_B, S_AC_WR_B, S_AC_RD_C, S_AC_WR_C,
        S_RS_RD, S_RT_GO, S_RT_WAIT, S_RB_GO, S_RB_WAIT, S_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQUARE, N_SQRT, N_DIVIDE, N_DONE
    } norm_state_t;

    typedef enum logic [1:0] {
        IDX_A, IDX_B, IDX_C
    } idx_sel_t;

    typedef enum logic [1:0] {
        CAP_NONE, CAP_A, CAP_B, CAP_C
    } cap_sel_t;

    typedef enum logic [3:0] {
        M_NONE,
        M_DU1DV2, M_DU2DV1,
        M_DV2E1X, M_DV1E2X, M_DV2E1Y, M_DV1E2Y, M_DV2E1Z, M_DV1E2Z,
        M_N1T2, M_N2T1, M_N2T0, M_N0T2, M_N0T1, M_N1T0
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_NONE, ST_DET, ST_RAW0, ST_RAW1, ST_RAW2,
        ST_BT0, ST_BT1, ST_BT2, ST_T, ST_N, ST_BTN
    } st_sel_t;

    typedef enum logic [1:0] {
        NS_RAW, NS_NORMAL, NS_TSUM, NS_BSUM
    } norm_src_t;

    typedef struct packed {
        logic      latch;
        idx_sel_t  idx_sel;
        logic      load_wr;
        logic      sum_wr;
        cap_sel_t  cap;
        mul_sel_t  mul;
        acc_op_t   acc;
        st_sel_t   st;
        logic      norm_start;
        norm_src_t norm_src;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      a_ok;
        logic      all_ok;
        logic      det_zero;
        logic      norm_done;
        logic      norm_nz;
        logic      out_free;
    } dp_stat_t;

endpackage

// File: src/tangent_space_accumulator.sv
// Per-vertex tangent space accumulator, Q16.16. One word at a time.
// A load writes the vertex. A read normalizes both sums, then waits out any
// output stall. A triangle takes two normalizations. A normalization has a
// 32-step square root and a 17-step divide; a zero vector skips both.
// Reset clears the control state only; the vertex stores come up undefined
// and a vertex must be loaded before a triangle or read uses it.
module tangent_space_accumulator
    import tsa_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // index_a, index_b, index_c, pos_x, pos_y, pos_z, tex_u, tex_v,
    // norm_x, norm_y, norm_z, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // vertex_index, tangent_x, tangent_y, tangent_z, bitangent_x,
    // bitangent_y, bitangent_z, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsa_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: src/tsa_norm.sv
// Iterative vector normalizer: scales three signed 64-bit components to a
// Q16.16 unit vector by shift, sum of squares, bit-serial square root and
// three restoring dividers. Depends on tsa_pkg.
module tsa_norm
    import tsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0][63:0] vec,
    output logic             done,
    output logic             nz,
    output logic [2:0][31:0] o
);

    norm_state_t state_reg, state_next;

    logic [2:0][63:0] m_reg;
    logic [2:0]       neg_reg;
    logic [2:0][16:0] q_reg;
    logic [2:0][31:0] rem_reg;
    logic [2:0]       low_reg;
    logic             nz_reg;
    logic [4:0]       cnt_reg;
    logic [59:0]      sq_reg;
    logic [63:0]      s_reg;
    logic [63:0]      r_reg;

    logic [63:0] mor;
    logic        in_range;
    logic [29:0] sq_src;
    logic [59:0] sq_full;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [31:0] len;

    assign mor      = m_reg[0] | m_reg[1] | m_reg[2];
    assign in_range = (mor[63:30] == '0) && mor[29];
    assign sq_src   = (cnt_reg[1:0] == 2'd3) ? '0 : m_reg[cnt_reg[1:0]][29:0];
    assign sq_full  = sq_src * sq_src;
    assign bitv     = 64'(1) << {cnt_reg, 1'b0};
    assign trial    = r_reg + bitv;
    assign len      = r_reg[31:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = (vec == '0) ? N_DONE : N_SHIFT;
                end
            end
            N_SHIFT:  if (in_range) state_next = N_SQUARE;
            N_SQUARE: if (cnt_reg == 5'd3) state_next = N_SQRT;
            N_SQRT:   if (cnt_reg == 5'd0) state_next = N_DIVIDE;
            N_DIVIDE: if (cnt_reg == 5'd0) state_next = N_DONE;
            N_DONE:   state_next = N_IDLE;
            default:  state_next = N_IDLE;
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        unique case (state_reg)
            N_DONE:  done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    nz_reg <= (vec != '0);
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vec[i][63];
                        m_reg[i]   <= vec[i][63] ? 64'(0) - vec[i] : vec[i];
                        q_reg[i]   <= '0;
                    end
                end
            end
            N_SHIFT:
            begin
                // Coarse steps first, then single bits, until the largest
                // magnitude has its top bit at position 29.
                for (int i = 0; i < 3; i++)
                begin
                    priority if (mor[63:38] != '0)
                        m_reg[i] <= m_reg[i] >> 8;
                    else if (mor[63:30] != '0)
                        m_reg[i] <= m_reg[i] >> 1;
                    else if (mor[63:21] == '0)
                        m_reg[i] <= m_reg[i] << 8;
                    else if (!mor[29])
                        m_reg[i] <= m_reg[i] << 1;
                end
                cnt_reg <= '0;
                s_reg   <= '0;
            end
            N_SQUARE:
            begin
                sq_reg <= sq_full;
                if (cnt_reg != 5'd0)
                begin
                    s_reg <= s_reg + 64'(sq_reg);
                end
                if (cnt_reg == 5'd3)
                begin
                    cnt_reg <= 5'd31;
                    r_reg   <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            N_SQRT:
            begin
                if (s_reg >= trial)
                begin
                    s_reg <= s_reg - trial;
                    r_reg <= (r_reg >> 1) + bitv;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                if (cnt_reg == 5'd0)
                begin
                    cnt_reg <= 5'd16;
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_reg[i] <= {3'b000, m_reg[i][29:1]};
                        low_reg[i] <= m_reg[i][0];
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            N_DIVIDE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({rem_reg[i], low_reg[i]} >= {1'b0, len})
                    begin
                        rem_reg[i] <= 32'({rem_reg[i], low_reg[i]} - {1'b0, len});
                        q_reg[i]   <= {q_reg[i][15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= {rem_reg[i][30:0], low_reg[i]};
                        q_reg[i]   <= {q_reg[i][15:0], 1'b0};
                    end
                    low_reg[i] <= 1'b0;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            N_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o[i] = neg_reg[i] ? 32'(0) - {15'b0, q_reg[i]} : {15'b0, q_reg[i]};
        end
    end

    assign nz = nz_reg;

    // The square root must have produced a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_DIVIDE |-> len != '0)
        else $error("normalizer divides by zero length");

    // A unit component never exceeds one in Q16.16.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_DONE |-> (q_reg[0] <= 17'h10000) && (q_reg[1] <= 17'h10000)
                                && (q_reg[2] <= 17'h10000))
        else $error("normalized component above one");

endmodule

// File: src/tsa_datapath.sv
// Datapath of the tangent space accumulator: vertex and sum memories,
// input and output words, shared multiplier and accumulator, normalizer.
// Depends on tsa_pkg and tsa_norm.
module tsa_datapath
    import tsa_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    function automatic logic [31:0] sat_op(input logic [31:0] x, input logic [31:0] y,
                                           input logic sub);
        logic [32:0] s;
        s = sub ? {x[31], x} - {y[31], y} : {x[31], x} + {y[31], y};
        if (s[32] != s[31])
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        return s[31:0];
    endfunction

    function automatic logic [31:0] round_q16(input logic [63:0] x);
        logic [63:0] m;
        logic [63:0] q;
        m = x[63] ? 64'(0) - x : x;
        q = (m + 64'd32768) >> 16;
        return x[63] ? 32'(0) - q[31:0] : q[31:0];
    endfunction

    // Latched input word
    cmd_code_t        cmd_code_reg;
    logic [IDX_W-1:0] idx_a_reg, idx_b_reg, idx_c_reg;
    logic [2:0][31:0] in_pos_reg, in_norm_reg;
    logic [1:0][31:0] in_tex_reg;

    // Memories, one word per vertex
    logic [95:0] pos_mem  [MAX_VERTICES];
    logic [63:0] tex_mem  [MAX_VERTICES];
    logic [95:0] norm_mem [MAX_VERTICES];
    logic [95:0] tsum_mem [MAX_VERTICES];
    logic [95:0] bsum_mem [MAX_VERTICES];
    logic [2:0][31:0] pos_q, norm_q, tsum_q, bsum_q;
    logic [1:0][31:0] tex_q;

    logic [IDX_W-1:0]    idx_sel;
    logic [AW+IDX_W-1:0] idx_ext;
    logic [AW-1:0]       addr;
    logic                sum_we;
    logic [2:0][31:0]    tsum_wd, bsum_wd;

    // Working registers
    logic [2:0][31:0] pa_reg, na_reg, e1_reg, e2_reg;
    logic [1:0][31:0] ta_reg;
    logic [31:0]      du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic [2:0][63:0] raw_reg;
    logic [63:0]      det_reg;
    logic [2:0][31:0] t_reg, n_reg, bt_reg;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod_reg;
    logic [63:0]        acc_reg;

    logic [2:0][63:0] norm_vec;
    logic             norm_done, norm_nz;
    logic [2:0][31:0] norm_o;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_code_reg <= cmd_code_t'(s_tuser);
            idx_a_reg    <= s_tdata[9:0];
            idx_b_reg    <= s_tdata[19:10];
            idx_c_reg    <= s_tdata[29:20];
            in_pos_reg   <= s_tdata[125:30];
            in_tex_reg   <= s_tdata[189:126];
            in_norm_reg  <= s_tdata[285:190];
        end
    end

    always_comb
    begin
        unique case (cmd.idx_sel)
            IDX_A:   idx_sel = idx_a_reg;
            IDX_B:   idx_sel = idx_b_reg;
            IDX_C:   idx_sel = idx_c_reg;
            default: idx_sel = idx_a_reg;
        endcase
    end

    assign idx_ext = {{AW{1'b0}}, idx_sel};
    assign addr    = idx_ext[AW-1:0];
    assign sum_we  = cmd.load_wr | cmd.sum_wr;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tsum_wd[i] = cmd.load_wr ? '0 : sat_op(tsum_q[i], t_reg[i], 1'b0);
            bsum_wd[i] = cmd.load_wr ? '0 : sat_op(bsum_q[i], bt_reg[i], 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            pos_mem[addr]  <= in_pos_reg;
            tex_mem[addr]  <= in_tex_reg;
            norm_mem[addr] <= in_norm_reg;
        end
        if (sum_we)
        begin
            tsum_mem[addr] <= tsum_wd;
            bsum_mem[addr] <= bsum_wd;
        end
        pos_q  <= pos_mem[addr];
        tex_q  <= tex_mem[addr];
        norm_q <= norm_mem[addr];
        tsum_q <= tsum_mem[addr];
        bsum_q <= bsum_mem[addr];
    end

    // Corner capture: the second and third corners are stored as edges.
    always_ff @(posedge clk)
    begin
        unique case (cmd.cap)
            CAP_A:
            begin
                pa_reg <= pos_q;
                ta_reg <= tex_q;
                na_reg <= norm_q;
            end
            CAP_B:
            begin
                for (int i = 0; i < 3; i++)
                    e1_reg[i] <= sat_op(pos_q[i], pa_reg[i], 1'b1);
                du1_reg <= sat_op(tex_q[0], ta_reg[0], 1'b1);
                dv1_reg <= sat_op(tex_q[1], ta_reg[1], 1'b1);
            end
            CAP_C:
            begin
                for (int i = 0; i < 3; i++)
                    e2_reg[i] <= sat_op(pos_q[i], pa_reg[i], 1'b1);
                du2_reg <= sat_op(tex_q[0], ta_reg[0], 1'b1);
                dv2_reg <= sat_op(tex_q[1], ta_reg[1], 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.mul)
            M_DU1DV2: begin ma = du1_reg;   mb = dv2_reg;  end
            M_DU2DV1: begin ma = du2_reg;   mb = dv1_reg;  end
            M_DV2E1X: begin ma = dv2_reg;   mb = e1_reg[0]; end
            M_DV1E2X: begin ma = dv1_reg;   mb = e2_reg[0]; end
            M_DV2E1Y: begin ma = dv2_reg;   mb = e1_reg[1]; end
            M_DV1E2Y: begin ma = dv1_reg;   mb = e2_reg[1]; end
            M_DV2E1Z: begin ma = dv2_reg;   mb = e1_reg[2]; end
            M_DV1E2Z: begin ma = dv1_reg;   mb = e2_reg[2]; end
            M_N1T2:   begin ma = n_reg[1];  mb = t_reg[2];  end
            M_N2T1:   begin ma = n_reg[2];  mb = t_reg[1];  end
            M_N2T0:   begin ma = n_reg[2];  mb = t_reg[0];  end
            M_N0T2:   begin ma = n_reg[0];  mb = t_reg[2];  end
            M_N0T1:   begin ma = n_reg[0];  mb = t_reg[1];  end
            M_N1T0:   begin ma = n_reg[1];  mb = t_reg[0];  end
            default:  begin ma = '0;        mb = '0;        end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(ma) * 64'(mb);
        unique case (cmd.acc)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_SUB:  acc_reg <= acc_reg - prod_reg;
            default:  acc_reg <= acc_reg;
        endcase
        unique case (cmd.st)
            ST_DET:  det_reg    <= acc_reg;
            ST_RAW0: raw_reg[0] <= acc_reg;
            ST_RAW1: raw_reg[1] <= acc_reg;
            ST_RAW2: raw_reg[2] <= acc_reg;
            ST_BT0:  bt_reg[0]  <= round_q16(acc_reg);
            ST_BT1:  bt_reg[1]  <= round_q16(acc_reg);
            ST_BT2:  bt_reg[2]  <= round_q16(acc_reg);
            ST_T:    t_reg      <= norm_o;
            ST_N:    n_reg      <= norm_o;
            ST_BTN:  bt_reg     <= norm_o;
            default:
            begin
            end
        endcase
    end

    // The tangent direction flips with the sign of the UV determinant.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (cmd.norm_src)
                NS_RAW:    norm_vec[i] = det_reg[63] ? 64'(0) - raw_reg[i] : raw_reg[i];
                NS_NORMAL: norm_vec[i] = {{32{na_reg[i][31]}}, na_reg[i]};
                NS_TSUM:   norm_vec[i] = {{32{tsum_q[i][31]}}, tsum_q[i]};
                NS_BSUM:   norm_vec[i] = {{32{bsum_q[i][31]}}, bsum_q[i]};
                default:   norm_vec[i] = '0;
            endcase
        end
    end

    tsa_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.norm_start),
        .vec   (norm_vec),
        .done  (norm_done),
        .nz    (norm_nz),
        .o     (norm_o)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // An index beyond the store reads back with zero tangent and bitangent fields.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (stat.a_ok)
                m_tdata_reg <= {6'b0, bt_reg, t_reg, idx_a_reg};
            else
                m_tdata_reg <= {6'b0, 192'b0, idx_a_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.cmd       = cmd_code_reg;
    assign stat.a_ok      = 32'(idx_a_reg) < 32'(MAX_VERTICES);
    assign stat.all_ok    = stat.a_ok && (32'(idx_b_reg) < 32'(MAX_VERTICES))
                            && (32'(idx_c_reg) < 32'(MAX_VERTICES));
    assign stat.det_zero  = (det_reg == '0);
    assign stat.norm_done = norm_done;
    assign stat.norm_nz   = norm_nz;
    assign stat.out_free  = out_free;

    // A result word is only loaded when the previous one is gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten before it was taken");

endmodule

// File: src/tsa_ctrl.sv
// Controller state machine of the tangent space accumulator. Sequences
// loads, triangle accumulation and reads through dp_cmd_t. Depends on tsa_pkg.
module tsa_ctrl
    import tsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_LOAD: state_next = stat.a_ok ? S_LOAD : S_IDLE;
                    CMD_TRI:  state_next = stat.all_ok ? S_TRI_RD_A : S_IDLE;
                    CMD_READ: state_next = stat.a_ok ? S_RS_RD : S_OUT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_LOAD:     state_next = S_IDLE;
            S_TRI_RD_A: state_next = S_TRI_RD_B;
            S_TRI_RD_B: state_next = S_TRI_RD_C;
            S_TRI_RD_C: state_next = S_TRI_DIFF;
            S_TRI_DIFF: state_next = S_MUL_0;
            S_MUL_0:    state_next = S_MUL_1;
            S_MUL_1:    state_next = S_MUL_2;
            S_MUL_2:    state_next = S_MUL_3;
            S_MUL_3:    state_next = S_MUL_4;
            S_MUL_4:    state_next = S_MUL_5;
            S_MUL_5:    state_next = S_MUL_6;
            S_MUL_6:    state_next = S_MUL_7;
            S_MUL_7:    state_next = S_MUL_8;
            S_MUL_8:    state_next = S_MUL_9;
            // A zero UV determinant means a degenerate triangle.
            S_MUL_9:    state_next = stat.det_zero ? S_IDLE : S_TN_GO;
            S_TN_GO:    state_next = S_TN_WAIT;
            S_TN_WAIT:
            begin
                if (stat.norm_done)
                    state_next = stat.norm_nz ? S_NN_GO : S_IDLE;
            end
            S_NN_GO:    state_next = S_NN_WAIT;
            S_NN_WAIT:  if (stat.norm_done) state_next = S_BT_0;
            S_BT_0:     state_next = S_BT_1;
            S_BT_1:     state_next = S_BT_2;
            S_BT_2:     state_next = S_BT_3;
            S_BT_3:     state_next = S_BT_4;
            S_BT_4:     state_next = S_BT_5;
            S_BT_5:     state_next = S_BT_6;
            S_BT_6:     state_next = S_BT_7;
            S_BT_7:     state_next = S_AC_RD_A;
            S_AC_RD_A:  state_next = S_AC_WR_A;
            S_AC_WR_A:  state_next = S_AC_RD_B;
            S_AC_RD_B:  state_next = S_AC_WR_B;
            S_AC_WR_B:  state_next = S_AC_RD_C;
            S_AC_RD_C:  state_next = S_AC_WR_C;
            S_AC_WR_C:  state_next = S_IDLE;
            S_RS_RD:    state_next = S_RT_GO;
            S_RT_GO:    state_next = S_RT_WAIT;
            S_RT_WAIT:  if (stat.norm_done) state_next = S_RB_GO;
            S_RB_GO:    state_next = S_RB_WAIT;
            S_RB_WAIT:  if (stat.norm_done) state_next = S_OUT;
            S_OUT:      if (stat.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            S_LOAD:     cmd.load_wr = 1'b1;
            S_TRI_RD_A: cmd.idx_sel = IDX_A;
            S_TRI_RD_B:
            begin
                cmd.idx_sel = IDX_B;
                cmd.cap     = CAP_A;
            end
            S_TRI_RD_C:
            begin
                cmd.idx_sel = IDX_C;
                cmd.cap     = CAP_B;
            end
            S_TRI_DIFF: cmd.cap = CAP_C;
            // Products land in the cycle after their operands are chosen.
            S_MUL_0: cmd.mul = M_DU1DV2;
            S_MUL_1: begin cmd.mul = M_DU2DV1; cmd.acc = ACC_LOAD; end
            S_MUL_2: begin cmd.mul = M_DV2E1X; cmd.acc = ACC_SUB;  end
            S_MUL_3: begin cmd.mul = M_DV1E2X; cmd.acc = ACC_LOAD; cmd.st = ST_DET;  end
            S_MUL_4: begin cmd.mul = M_DV2E1Y; cmd.acc = ACC_SUB;  end
            S_MUL_5: begin cmd.mul = M_DV1E2Y; cmd.acc = ACC_LOAD; cmd.st = ST_RAW0; end
            S_MUL_6: begin cmd.mul = M_DV2E1Z; cmd.acc = ACC_SUB;  end
            S_MUL_7: begin cmd.mul = M_DV1E2Z; cmd.acc = ACC_LOAD; cmd.st = ST_RAW1; end
            S_MUL_8: cmd.acc = ACC_SUB;
            S_MUL_9: cmd.st  = ST_RAW2;
            S_TN_GO:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_src   = NS_RAW;
            end
            S_TN_WAIT: if (stat.norm_done) cmd.st = ST_T;
            S_NN_GO:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_src   = NS_NORMAL;
            end
            S_NN_WAIT: if (stat.norm_done) cmd.st = ST_N;
            S_BT_0: cmd.mul = M_N1T2;
            S_BT_1: begin cmd.mul = M_N2T1; cmd.acc = ACC_LOAD; end
            S_BT_2: begin cmd.mul = M_N2T0; cmd.acc = ACC_SUB;  end
            S_BT_3: begin cmd.mul = M_N0T2; cmd.acc = ACC_LOAD; cmd.st = ST_BT0; end
            S_BT_4: begin cmd.mul = M_N0T1; cmd.acc = ACC_SUB;  end
            S_BT_5: begin cmd.mul = M_N1T0; cmd.acc = ACC_LOAD; cmd.st = ST_BT1; end
            S_BT_6: cmd.acc = ACC_SUB;
            S_BT_7: cmd.st  = ST_BT2;
            S_AC_RD_A: cmd.idx_sel = IDX_A;
            S_AC_WR_A: begin cmd.idx_sel = IDX_A; cmd.sum_wr = 1'b1; end
            S_AC_RD_B: cmd.idx_sel = IDX_B;
            S_AC_WR_B: begin cmd.idx_sel = IDX_B; cmd.sum_wr = 1'b1; end
            S_AC_RD_C: cmd.idx_sel = IDX_C;
            S_AC_WR_C: begin cmd.idx_sel = IDX_C; cmd.sum_wr = 1'b1; end
            S_RT_GO:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_src   = NS_TSUM;
            end
            S_RT_WAIT: if (stat.norm_done) cmd.st = ST_T;
            S_RB_GO:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_src   = NS_BSUM;
            end
            S_RB_WAIT: if (stat.norm_done) cmd.st = ST_BTN;
            S_OUT:     cmd.out_load = stat.out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Each sum update reads in a read state and writes in the write state after it, so two
    // writes in a row would mean a corner read stale data.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_wr |=> !cmd.sum_wr)
        else $error("back to back sum writes");

    // The normalizer is always idle when it is started.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.norm_start |-> !stat.norm_done)
        else $error("normalizer started while still finishing");

endmodule

// File: bench/tsa_checker.sv
// Scoreboard for the tangent space accumulator: watches both stream channels,
// predicts each read result from its own copy of the vertex stores and
// compares it. Depends on tsa_pkg.
module tsa_checker
    import tsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatch_count,
    output int                   pending_reads
);

    localparam int NVERT = 1024;

    typedef longint wide3_t[3];
    typedef int     vec3_t[3];

    int pos_mem[NVERT*3];
    int uv_mem[NVERT*2];
    int nrm_mem[NVERT*3];
    int tsum_mem[NVERT*3];
    int bsum_mem[NVERT*3];

    logic [M_TDATA_W-1:0] read_results_q[$];

    function automatic int sat32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned step;
        r = 0;
        step = 64'h1 << 62;
        while (step > s)
            step = step >> 2;
        while (step != 0)
        begin
            if (s >= r + step)
            begin
                s = s - (r + step);
                r = (r >> 1) + step;
            end
            else
                r = r >> 1;
            step = step >> 2;
        end
        return r;
    endfunction

    // Scale so the largest magnitude sits in [2^29, 2^30), then divide by the length.
    function automatic vec3_t unit_vec(wide3_t v);
        longint unsigned m[3];
        longint unsigned big;
        longint unsigned s;
        longint unsigned len;
        bit              neg[3];
        longint          q;
        vec3_t           o;
        big = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? 64'd0 - longint'(v[i]) : longint'(v[i]);
            if (m[i] > big)
                big = m[i];
        end
        if (big == 0)
            return '{0, 0, 0};
        while (big >= (64'h1 << 30))
        begin
            big = big >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (big < (64'h1 << 29))
        begin
            big = big << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            s = s + m[i] * m[i];
        len = isqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = longint'((m[i] << 16) / len);
            o[i] = int'(neg[i] ? -q : q);
        end
        return o;
    endfunction

    function automatic int round_q16(longint x);
        longint unsigned m;
        longint          q;
        m = (x < 0) ? 64'd0 - x : x;
        q = longint'((m + 64'd32768) >> 16);
        return int'((x < 0) ? -q : q);
    endfunction

    task automatic accumulate_triangle(int a, int b, int c);
        longint e1[3];
        longint e2[3];
        wide3_t raw;
        wide3_t nv;
        longint du1, dv1, du2, dv2, det;
        vec3_t  t;
        vec3_t  n;
        vec3_t  bt;
        int     corner[3];
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = sat32(longint'(pos_mem[b*3+i]) - pos_mem[a*3+i]);
            e2[i] = sat32(longint'(pos_mem[c*3+i]) - pos_mem[a*3+i]);
        end
        du1 = sat32(longint'(uv_mem[b*2]) - uv_mem[a*2]);
        dv1 = sat32(longint'(uv_mem[b*2+1]) - uv_mem[a*2+1]);
        du2 = sat32(longint'(uv_mem[c*2]) - uv_mem[a*2]);
        dv2 = sat32(longint'(uv_mem[c*2+1]) - uv_mem[a*2+1]);
        det = du1 * dv2 - du2 * dv1;
        if (det == 0)
            return;
        for (int i = 0; i < 3; i++)
        begin
            raw[i] = dv2 * e1[i] - dv1 * e2[i];
            if (det < 0)
                raw[i] = -raw[i];
        end
        // A zero tangent direction means the triangle is skipped.
        if (raw[0] == 0 && raw[1] == 0 && raw[2] == 0)
            return;
        t = unit_vec(raw);
        for (int i = 0; i < 3; i++)
            nv[i] = nrm_mem[a*3+i];
        n = unit_vec(nv);
        bt[0] = round_q16(longint'(n[1]) * t[2] - longint'(n[2]) * t[1]);
        bt[1] = round_q16(longint'(n[2]) * t[0] - longint'(n[0]) * t[2]);
        bt[2] = round_q16(longint'(n[0]) * t[1] - longint'(n[1]) * t[0]);
        corner = '{a, b, c};
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
            begin
                tsum_mem[corner[k]*3+i] = sat32(longint'(tsum_mem[corner[k]*3+i]) + t[i]);
                bsum_mem[corner[k]*3+i] = sat32(longint'(bsum_mem[corner[k]*3+i]) + bt[i]);
            end
    endtask

    function automatic logic [M_TDATA_W-1:0] predict_read(int a);
        wide3_t               ts;
        wide3_t               bs;
        vec3_t                t;
        vec3_t                bt;
        logic [M_TDATA_W-1:0] w;
        for (int i = 0; i < 3; i++)
        begin
            ts[i] = tsum_mem[a*3+i];
            bs[i] = bsum_mem[a*3+i];
        end
        t = unit_vec(ts);
        bt = unit_vec(bs);
        w = '0;
        w[IDX_W-1:0] = a[IDX_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            w[IDX_W + 32*i +: 32] = t[i];
            w[IDX_W + 32*(i+3) +: 32] = bt[i];
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [M_TDATA_W-1:0] want;
        int                   a, b, c;
        if (!rst_n)
        begin
            read_results_q.delete();
            mismatch_count = 0;
            pending_reads = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                a = s_tdata[9:0];
                b = s_tdata[19:10];
                c = s_tdata[29:20];
                case (cmd_code_t'(s_tuser))
                    CMD_LOAD:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pos_mem[a*3+i] = s_tdata[30 + 32*i +: 32];
                            nrm_mem[a*3+i] = s_tdata[190 + 32*i +: 32];
                            tsum_mem[a*3+i] = 0;
                            bsum_mem[a*3+i] = 0;
                        end
                        uv_mem[a*2] = s_tdata[126 +: 32];
                        uv_mem[a*2+1] = s_tdata[158 +: 32];
                    end
                    CMD_TRI:
                        accumulate_triangle(a, b, c);
                    CMD_READ:
                    begin
                        read_results_q = {read_results_q, predict_read(a)};
                        pending_reads++;
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (read_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = read_results_q.pop_front();
                    pending_reads--;
                    if (m_tdata[IDX_W-1:0] !== want[IDX_W-1:0])
                    begin
                        $display("%0t: vertex_index expected %0d actual %0d", $time,
                                 want[IDX_W-1:0], m_tdata[IDX_W-1:0]);
                        mismatch_count++;
                    end
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[IDX_W + 32*k +: 32] !== want[IDX_W + 32*k +: 32])
                        begin
                            $display("%0t: %s_%s of vertex %0d expected %h actual %h",
                                     $time, (k < 3) ? "tangent" : "bitangent",
                                     (k % 3 == 0) ? "x" : (k % 3 == 1) ? "y" : "z",
                                     want[IDX_W-1:0], want[IDX_W + 32*k +: 32],
                                     m_tdata[IDX_W + 32*k +: 32]);
                            mismatch_count++;
                        end
                end
            end
        end
    end

endmodule

// File: bench/tb_top.sv
// Top of the tangent space accumulator testbench: clock, reset, stimulus with
// bursty sending and a stalling receiver, and the verdict. Depends on tsa_pkg,
// tsa_checker and the block itself.
module tb_top;
    import tsa_pkg::*;

    localparam int Q_ONE     = 32'sh00010000;
    localparam int INT_MAXV  = 32'sh7fffffff;
    localparam int INT_MINV  = 32'sh80000000;
    localparam int CYCLE_CAP = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   mismatch_count;
    int                   pending_reads;

    int unsigned loaded_q[$];
    int          burst_left;

    tangent_space_accumulator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tsa_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatch_count(mismatch_count), .pending_reads(pending_reads)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Receiver stalls change character in turn: always ready, mostly ready, ready half the time.
    initial
    begin
        int cyc;
        m_tready = 1'b0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            case ((cyc / 300) % 3)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom % 4) != 0;
                default: m_tready <= ($urandom % 2) != 0;
            endcase
        end
    end

    function automatic int rand_coord();
        case ($urandom % 8)
            0:
                case ($urandom % 4)
                    0:       return INT_MAXV;
                    1:       return INT_MINV;
                    2:       return 0;
                    default: return -1;
                endcase
            1, 2:    return $urandom;
            default: return int'($urandom_range(0, 32'h100000)) - 32'h80000;
        endcase
    endfunction

    function automatic int rand_normal();
        case ($urandom % 16)
            0:       return 0;
            1:       return $urandom;
            default: return int'($urandom_range(0, 32'h20000)) - Q_ONE;
        endcase
    endfunction

    // Drives one word; bursts of random length are separated by random gaps.
    task automatic send_word(cmd_code_t cmd, logic [S_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic load_vertex(int a, int px, int py, int pz, int u, int v,
                               int nx, int ny, int nz);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[9:0] = a[9:0];
        d[19:10] = $urandom;
        d[29:20] = $urandom;
        d[30 +: 32] = px;
        d[62 +: 32] = py;
        d[94 +: 32] = pz;
        d[126 +: 32] = u;
        d[158 +: 32] = v;
        d[190 +: 32] = nx;
        d[222 +: 32] = ny;
        d[254 +: 32] = nz;
        if (!(a inside {loaded_q}))
            loaded_q = {loaded_q, a};
        send_word(CMD_LOAD, d);
    endtask

    // Triangle, read and unused commands carry random noise in the unused fields.
    task automatic send_indexed(cmd_code_t cmd, int a, int b, int c);
        logic [S_TDATA_W-1:0] d;
        for (int i = 0; i < S_TDATA_W / 32; i++)
            d[32*i +: 32] = $urandom;
        d[S_TDATA_W-1:S_TDATA_W-2] = '0;
        d[9:0] = a[9:0];
        d[19:10] = b[9:0];
        d[29:20] = c[9:0];
        send_word(cmd, d);
    endtask

    function automatic int pick_loaded();
        return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    endfunction

    initial
    begin
        int r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_vertex(0, 0, 0, 0, 0, 0, 0, 0, Q_ONE);
        load_vertex(1, Q_ONE, 0, 0, Q_ONE, 0, 0, 0, Q_ONE);
        load_vertex(2, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0);
        load_vertex(3, INT_MAXV, INT_MAXV, INT_MINV, INT_MINV, INT_MAXV,
                    INT_MINV, INT_MINV, INT_MINV);
        load_vertex(1023, INT_MINV, INT_MINV, INT_MAXV, INT_MAXV, INT_MINV,
                    INT_MAXV, INT_MAXV, INT_MAXV);
        load_vertex(4, Q_ONE, Q_ONE, Q_ONE, 0, 0, Q_ONE, 0, 0);
        load_vertex(5, 0, 0, 0, Q_ONE, 0, 0, Q_ONE, 0);
        load_vertex(6, 0, 0, 0, 0, Q_ONE, 0, Q_ONE, 0);
        send_indexed(CMD_READ, 0, 0, 0);
        send_indexed(CMD_TRI, 0, 1, 2);
        send_indexed(CMD_TRI, 2, 1, 0);
        send_indexed(CMD_TRI, 0, 0, 1);
        send_indexed(CMD_TRI, 0, 4, 1);
        send_indexed(CMD_TRI, 0, 5, 6);
        send_indexed(CMD_TRI, 2, 0, 1);
        send_indexed(CMD_TRI, 0, 3, 1023);
        send_indexed(CMD_TRI, 1023, 3, 0);
        send_indexed(CMD_NOP, 1, 2, 3);
        send_indexed(CMD_READ, 0, 0, 0);
        send_indexed(CMD_READ, 1, 0, 0);
        send_indexed(CMD_READ, 2, 0, 0);
        send_indexed(CMD_READ, 3, 0, 0);
        send_indexed(CMD_READ, 1023, 0, 0);
        send_indexed(CMD_READ, 4, 0, 0);

        for (int n = 0; n < 450; n++)
        begin
            r = $urandom % 100;
            if (r < 22)
                load_vertex(($urandom % 4 == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_normal(), rand_normal(), rand_normal());
            else if (r < 65)
                send_indexed(CMD_TRI, pick_loaded(), pick_loaded(), pick_loaded());
            else if (r < 95)
                send_indexed(CMD_READ, pick_loaded(), 0, 0);
            else
                send_indexed(CMD_NOP, $urandom, $urandom, $urandom);
        end
        s_tvalid <= 1'b0;

        while (pending_reads != 0)
            @(negedge clk);
        // A trailing triangle can still be in flight; give it time to finish.
        repeat (400) @(negedge clk);
        if (mismatch_count == 0 && pending_reads == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
